// ===== rtl/core/sals_pkg.sv =====
// shared constants, types and register codes of the line score block
package sals_pkg;

    localparam int LEVEL_W         = 8;
    localparam int COUNT_W         = 13;
    localparam int SUM_W           = 38;
    localparam int MEAN_W          = 25;
    localparam int REM_W           = COUNT_W + 1;
    localparam int DIV_STEPS       = SUM_W;
    localparam int STEP_W          = 6;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [COUNT_W-1:0] MAX_LINE_PIXELS = COUNT_W'(4096);
    localparam logic [STEP_W-1:0]  DIV_LAST        = STEP_W'(DIV_STEPS - 1);

    // register index codes, taken from paddr[2]
    localparam logic REG_DARKNESS    = 1'b0;
    localparam logic REG_USE_WEIGHTS = 1'b1;

    localparam logic [LEVEL_W-1:0] DARKNESS_RESET    = 8'd60;
    localparam logic               USE_WEIGHTS_RESET = 1'b1;
    localparam logic [LEVEL_W-1:0] WEIGHT_ONE        = 8'd16;

    typedef struct packed {
        logic [LEVEL_W-1:0] darkness;
        logic               use_weights;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic div_start;
        logic div_step;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic line_end_accept;
        logic pipe_busy;
        logic out_full;
    } ctrl_status_t;

endpackage

// ===== rtl/core/sals_if.sv =====
// pixel and score stream interfaces of the line score block
interface sals_pixel_if;
    logic                           valid;
    logic                           ready;
    logic [sals_pkg::LEVEL_W-1:0]   target_level;
    logic [sals_pkg::LEVEL_W-1:0]   canvas_level;
    logic [sals_pkg::LEVEL_W-1:0]   weight_q4;
    logic                           last_pixel;

    modport source (output valid, target_level, canvas_level, weight_q4, last_pixel,
                    input ready);
    modport sink (input valid, target_level, canvas_level, weight_q4, last_pixel,
                  output ready);
endinterface

interface sals_score_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sals_pkg::MEAN_W-1:0]   mean_score;
    logic        [sals_pkg::COUNT_W-1:0]  pixel_count;

    modport source (output valid, mean_score, pixel_count, input ready);
    modport sink (input valid, mean_score, pixel_count, output ready);
endinterface

// ===== rtl/core/string_art_line_score.sv =====
// top level of the line score block: register port, controller and datapath
//
// Scores one candidate thread line. Pixels of the line arrive on the pix
// channel (valid/ready), one transaction per pixel, at up to one per cycle.
// The transaction that carries last_pixel, or that brings the count to 4096,
// closes the line. pix.ready then drops while three product stages drain,
// a serial divider runs 38 steps (one quotient bit per cycle) and the result
// is loaded into the output register, which drives the score channel.
// The output register holds the result while the receiver stalls; pix.ready
// returns as soon as the result is loaded, so the next line can accumulate
// while it waits. A new result waits in the controller until the previous
// one is taken.
// Registers (APB, writes take effect at the access cycle, pready always high):
//   0x0 thread_darkness, 0x4 use_weights. Write them only while idle.
// Reset clears the sum, the pixel count and the output valid, and sets
// thread_darkness to 60 and use_weights to 1.
module string_art_line_score (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sals_pkg::PADDR_W-1:0]      paddr,
    input  logic [sals_pkg::PDATA_W-1:0]      pwdata,
    output logic [sals_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    sals_pixel_if.sink                        pix,
    sals_score_if.source                      score
);

    sals_pkg::cfg_t           cfg_reg;
    sals_pkg::ctrl_cmd_t      cmd;
    sals_pkg::ctrl_status_t   status;
    logic                     cfg_we;
    logic                     reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.darkness    <= sals_pkg::DARKNESS_RESET;
            cfg_reg.use_weights <= sals_pkg::USE_WEIGHTS_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_sel)
                sals_pkg::REG_DARKNESS:    cfg_reg.darkness    <= pwdata[sals_pkg::LEVEL_W-1:0];
                sals_pkg::REG_USE_WEIGHTS: cfg_reg.use_weights <= pwdata[0];
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            sals_pkg::REG_DARKNESS:
                prdata = sals_pkg::PDATA_W'(cfg_reg.darkness);
            sals_pkg::REG_USE_WEIGHTS:
                prdata = sals_pkg::PDATA_W'(cfg_reg.use_weights);
            default:
                prdata = '0;
        endcase
    end

    sals_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    sals_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .status (status),
        .pix    (pix),
        .score  (score)
    );

    // no pixel slips in behind the one that closes a line
    assert property (@(posedge clk) disable iff (!rst_n)
        status.line_end_accept |=> !pix.ready)
        else $error("pixel accepted after line end");

    // the divider only starts on a fully drained sum
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.pipe_busy)
        else $error("divide started with products in flight");

    // a result only appears after a load command
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(score.valid) |-> $past(cmd.out_load))
        else $error("result valid without load");

    // a waiting result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !status.out_full)
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/core/sals_ctrl.sv =====
// controller: accumulate, drain, divide and hand over the result
module sals_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sals_pkg::ctrl_status_t  status,
    output sals_pkg::ctrl_cmd_t     cmd
);

    localparam logic [1:0] ST_RUN   = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    logic [sals_pkg::STEP_W-1:0] step_reg;
    logic [sals_pkg::STEP_W-1:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        case (state_reg)
            ST_RUN:
            begin
                cmd.take = 1'b1;
                if (status.line_end_accept)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // sum is final once the product stages are empty
                if (!status.pipe_busy)
                begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == sals_pkg::DIV_LAST)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (!status.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== rtl/core/sals_datapath.sv =====
// datapath: pixel term pipeline, accumulator, serial divider, output register
module sals_datapath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sals_pkg::cfg_t          cfg,
    input  sals_pkg::ctrl_cmd_t     cmd,
    output sals_pkg::ctrl_status_t  status,
    sals_pixel_if.sink              pix,
    sals_score_if.source            score
);

    logic                                 accept;
    logic [sals_pkg::COUNT_W-1:0]         count_reg;
    logic [sals_pkg::COUNT_W-1:0]         count_inc;
    logic                                 line_end;
    logic [sals_pkg::COUNT_W-1:0]         divisor_reg;

    logic signed [8:0]                    d_c;
    logic [sals_pkg::LEVEL_W-1:0]         after_c;
    logic signed [8:0]                    e_raw_c;
    logic signed [8:0]                    e_c;
    logic [sals_pkg::LEVEL_W-1:0]         w_c;

    logic                                 s1_valid_reg;
    logic signed [8:0]                    d_reg;
    logic signed [8:0]                    e_reg;
    logic [sals_pkg::LEVEL_W-1:0]         w1_reg;

    logic signed [17:0]                   dsq_c;
    logic signed [17:0]                   esq_c;
    logic                                 s2_valid_reg;
    logic signed [17:0]                   diff_reg;
    logic [sals_pkg::LEVEL_W-1:0]         w2_reg;

    logic signed [26:0]                   prod_c;
    logic                                 s3_valid_reg;
    logic signed [26:0]                   prod_reg;

    logic signed [sals_pkg::SUM_W-1:0]    sum_reg;

    logic                                 neg_reg;
    logic [sals_pkg::SUM_W-1:0]           quo_reg;
    logic [sals_pkg::REM_W-1:0]           rem_reg;
    logic [sals_pkg::REM_W-1:0]           rem_sh_c;
    logic                                 rem_ge_c;
    logic [sals_pkg::MEAN_W-1:0]          q_low_c;
    logic [sals_pkg::MEAN_W-1:0]          mean_c;

    logic                                 out_valid_reg;
    logic signed [sals_pkg::MEAN_W-1:0]   mean_reg;
    logic [sals_pkg::COUNT_W-1:0]         out_count_reg;

    assign pix.ready = cmd.take;
    assign accept    = pix.valid && cmd.take;
    assign count_inc = count_reg + 1'b1;
    assign line_end  = pix.last_pixel || (count_inc == sals_pkg::MAX_LINE_PIXELS);

    // stage 1: errors before and after the thread
    assign d_c     = $signed({1'b0, pix.target_level}) - $signed({1'b0, pix.canvas_level});
    assign after_c = (pix.canvas_level > cfg.darkness) ? (pix.canvas_level - cfg.darkness)
                                                        : '0;
    assign e_raw_c = $signed({1'b0, pix.target_level}) - $signed({1'b0, after_c});
    // negative error halves toward zero
    assign e_c     = e_raw_c[8] ? ((e_raw_c + 9'sd1) >>> 1) : e_raw_c;
    assign w_c     = cfg.use_weights ? pix.weight_q4 : sals_pkg::WEIGHT_ONE;

    // stage 2: squares
    assign dsq_c = d_reg * d_reg;
    assign esq_c = e_reg * e_reg;

    // stage 3: weight
    assign prod_c = diff_reg * $signed({1'b0, w2_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (accept)
            begin
                count_reg <= line_end ? '0 : count_inc;
            end
            if (cmd.div_start)
            begin
                sum_reg <= '0;
            end
            else if (s3_valid_reg)
            begin
                sum_reg <= sum_reg + sals_pkg::SUM_W'(prod_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= d_c;
        e_reg    <= e_c;
        w1_reg   <= w_c;
        diff_reg <= dsq_c - esq_c;
        w2_reg   <= w1_reg;
        prod_reg <= prod_c;
        if (accept && line_end)
        begin
            divisor_reg <= count_inc;
        end
    end

    // restoring division of the sum magnitude, one quotient bit per step
    assign rem_sh_c = {rem_reg[sals_pkg::REM_W-2:0], quo_reg[sals_pkg::SUM_W-1]};
    assign rem_ge_c = rem_sh_c >= {1'b0, divisor_reg};
    assign q_low_c  = quo_reg[sals_pkg::MEAN_W-1:0];
    assign mean_c   = neg_reg ? (~q_low_c + 1'b1) : q_low_c;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            neg_reg <= sum_reg[sals_pkg::SUM_W-1];
            quo_reg <= sum_reg[sals_pkg::SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[sals_pkg::SUM_W-2:0], rem_ge_c};
            rem_reg <= rem_ge_c ? (rem_sh_c - {1'b0, divisor_reg}) : rem_sh_c;
        end
        if (cmd.out_load)
        begin
            mean_reg      <= $signed(mean_c);
            out_count_reg <= divisor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (score.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign score.valid       = out_valid_reg;
    assign score.mean_score  = mean_reg;
    assign score.pixel_count = out_count_reg;

    assign status.line_end_accept = accept && line_end;
    assign status.pipe_busy       = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign status.out_full        = out_valid_reg && !score.ready;

endmodule

// ===== sim/tb_top.sv =====
// testbench for the line score block: directed table, random lines, scoreboard against a predictor
`timescale 1ns / 1ps

module tb_top;

    localparam time CLK_PERIOD     = 4ns;
    localparam int  RESET_CYCLES   = 8;
    localparam int  DRAIN_CYCLES   = 60;
    localparam int  LONG_HOLD      = 800;
    localparam int  WATCHDOG_LIMIT = 4000;
    localparam int  PHASE_ITEMS    = 240;

    typedef struct packed {
        logic [sals_pkg::LEVEL_W-1:0] target;
        logic [sals_pkg::LEVEL_W-1:0] canvas;
        logic [sals_pkg::LEVEL_W-1:0] weight;
        logic                         last;
    } pixel_t;

    typedef struct packed {
        logic signed [sals_pkg::MEAN_W-1:0] mean;
        logic [sals_pkg::COUNT_W-1:0]       count;
    } score_t;

    typedef struct packed {
        logic [sals_pkg::LEVEL_W-1:0] darkness;
        logic                         use_weights;
        pixel_t                       px;
        logic                         known;
        score_t                       score;
    } vector_t;

    localparam int N_DIRECTED = 18;

    // darkness, use_weights, {target, canvas, weight, last}, known, {mean, count}
    localparam vector_t DIRECTED [0:N_DIRECTED-1] = '{
        // reset settings, negative after-error halved toward zero
        '{8'd60,  1'b1, '{8'd0,   8'd255, 8'd16,  1'b1}, 1'b1, '{25'sd889856, 13'd1}},
        // zero weight still counts the pixel
        '{8'd60,  1'b1, '{8'd0,   8'd255, 8'd0,   1'b1}, 1'b1, '{25'sd0, 13'd1}},
        '{8'd60,  1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{-25'sd918000, 13'd1}},
        '{8'd60,  1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd60,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd60,  1'b1, '{8'd128, 8'd200, 8'd17,  1'b1}, 1'b0, '{25'sd0, 13'd0}},
        // full darkness gives the score extremes
        '{8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b1}, 1'b1, '{25'sd16581375, 13'd1}},
        '{8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}, 1'b1, '{-25'sd16581375, 13'd1}},
        '{8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd255, 1'b1, '{8'd0,   8'd255, 8'd255, 1'b1}, 1'b1, '{25'sd16581375, 13'd3}},
        // odd negative sum, mean truncated toward zero
        '{8'd255, 1'b1, '{8'd1,   8'd0,   8'd255, 1'b0}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd255, 1'b1, '{8'd255, 8'd253, 8'd1,   1'b1}, 1'b0, '{25'sd0, 13'd0}},
        // weights off, pixel weight ignored
        '{8'd0,   1'b0, '{8'd0,   8'd255, 8'd0,   1'b1}, 1'b1, '{25'sd782336, 13'd1}},
        '{8'd0,   1'b0, '{8'd255, 8'd0,   8'd255, 1'b1}, 1'b1, '{25'sd0, 13'd1}},
        '{8'd0,   1'b0, '{8'd17,  8'd99,  8'd200, 1'b0}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd0,   1'b0, '{8'd230, 8'd12,  8'd7,   1'b1}, 1'b0, '{25'sd0, 13'd0}},
        '{8'd60,  1'b1, '{8'd100, 8'd100, 8'd16,  1'b1}, 1'b1, '{-25'sd57600, 13'd1}}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [sals_pkg::PADDR_W-1:0] paddr;
    logic [sals_pkg::PDATA_W-1:0] pwdata;
    logic [sals_pkg::PDATA_W-1:0] prdata;
    logic                         pready;

    sals_pixel_if pix_if ();
    sals_score_if score_if ();

    string_art_line_score u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_if),
        .score   (score_if)
    );

    // predictor state
    logic [sals_pkg::LEVEL_W-1:0] darkness_cfg = sals_pkg::DARKNESS_RESET;
    logic                         weights_cfg  = sals_pkg::USE_WEIGHTS_RESET;
    longint                       line_sum     = 0;
    int                           line_pixels  = 0;
    score_t                       pending_means[$];

    int fail_count   = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    bit hold_off_req = 1'b0;

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int pixel_gain(input logic [sals_pkg::LEVEL_W-1:0] t,
                                      input logic [sals_pkg::LEVEL_W-1:0] c,
                                      input logic [sals_pkg::LEVEL_W-1:0] w);
        int d;
        int after;
        int e;
        d = int'(t) - int'(c);
        after = int'(c) - int'(darkness_cfg);
        if (after < 0)
            after = 0;
        e = int'(t) - after;
        if (e < 0)
            e = e / 2;
        return (d * d - e * e) * int'(w);
    endfunction

    task automatic accumulate_line_score(input pixel_t px, input logic known,
                                         input score_t known_score);
        logic [sals_pkg::LEVEL_W-1:0] w;
        longint                       mean;
        score_t                       s;
        w = weights_cfg ? px.weight : sals_pkg::WEIGHT_ONE;
        line_sum += longint'(pixel_gain(px.target, px.canvas, w));
        line_pixels++;
        if (px.last || line_pixels >= int'(sals_pkg::MAX_LINE_PIXELS))
        begin
            mean = line_sum / longint'(line_pixels);
            s.mean = mean[sals_pkg::MEAN_W-1:0];
            s.count = line_pixels[sals_pkg::COUNT_W-1:0];
            if (known)
                s = known_score;
            pending_means = {pending_means, s};
            line_sum = 0;
            line_pixels = 0;
        end
    endtask

    task automatic send_pixel(input pixel_t px, input logic known, input score_t known_score);
        int gap;
        if (burst_left == 0)
        begin
            // a third of the bursts run straight into the next one
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
            repeat (gap)
            begin
                @(negedge clk);
                pix_if.valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 64);
        end
        @(negedge clk);
        pix_if.valid        <= 1'b1;
        pix_if.target_level <= px.target;
        pix_if.canvas_level <= px.canvas;
        pix_if.weight_q4    <= px.weight;
        pix_if.last_pixel   <= px.last;
        do
            @(posedge clk);
        while (!pix_if.ready);
        burst_left--;
        accumulate_line_score(px, known, known_score);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        pix_if.valid <= 1'b0;
        while (pending_means.size() != 0)
            @(posedge clk);
        // divider may still be busy with nothing owed
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic reg_write(input logic reg_idx, input logic [sals_pkg::PDATA_W-1:0] value);
        logic [sals_pkg::PDATA_W-1:0] mask;
        logic [sals_pkg::PDATA_W-1:0] stored;
        mask = (reg_idx == sals_pkg::REG_DARKNESS) ? sals_pkg::PDATA_W'(8'hFF)
                                                   : sals_pkg::PDATA_W'(1);
        stored = value & mask;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        // junk above the register width must be dropped
        pwdata  <= stored | ($urandom & ~mask);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (reg_idx == sals_pkg::REG_DARKNESS)
            darkness_cfg = stored[sals_pkg::LEVEL_W-1:0];
        else
            weights_cfg = stored[0];
        // read back
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== stored)
        begin
            $error("prdata expected %0h actual %0h", stored, prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [sals_pkg::LEVEL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return sals_pkg::LEVEL_W'($urandom);
        endcase
    endfunction

    task automatic send_line(input int len);
        pixel_t px;
        for (int k = 1; k <= len; k++)
        begin
            px.target = pick_level();
            px.canvas = pick_level();
            px.weight = pick_level();
            px.last   = (k == len);
            send_pixel(px, 1'b0, '0);
        end
    endtask

    task automatic random_phase(input logic [sals_pkg::LEVEL_W-1:0] dark, input logic use_w,
                                input bit squeeze);
        int sent;
        int r;
        int len;
        wait_idle();
        reg_write(sals_pkg::REG_DARKNESS, sals_pkg::PDATA_W'(dark));
        reg_write(sals_pkg::REG_USE_WEIGHTS, sals_pkg::PDATA_W'(use_w));
        if (squeeze)
            hold_off_req = 1'b1;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            r = $urandom_range(0, 19);
            if (r < 14)
                len = $urandom_range(1, 12);
            else if (r < 19)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(65, 300);
            send_line(len);
            sent += len;
        end
    endtask

    initial
    begin : main_seq
        rst_n   = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        pix_if.valid        = 1'b0;
        pix_if.target_level = '0;
        pix_if.canvas_level = '0;
        pix_if.weight_q4    = '0;
        pix_if.last_pixel   = 1'b0;
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].darkness !== darkness_cfg || DIRECTED[i].use_weights !== weights_cfg)
            begin
                wait_idle();
                if (DIRECTED[i].darkness !== darkness_cfg)
                    reg_write(sals_pkg::REG_DARKNESS,
                              sals_pkg::PDATA_W'(DIRECTED[i].darkness));
                if (DIRECTED[i].use_weights !== weights_cfg)
                    reg_write(sals_pkg::REG_USE_WEIGHTS,
                              sals_pkg::PDATA_W'(DIRECTED[i].use_weights));
            end
            send_pixel(DIRECTED[i].px, DIRECTED[i].known, DIRECTED[i].score);
        end

        random_phase(8'd0, 1'b1, 1'b0);
        random_phase(8'd255, 1'b0, 1'b0);
        random_phase(pick_level(), 1'b1, 1'b1);
        random_phase(pick_level(), 1'b0, 1'b0);
        random_phase(pick_level(), 1'($urandom), 1'b0);
        random_phase(8'd255, 1'b1, 1'b0);

        wait_idle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin : score_sink
        int mode;
        int span;
        int hold;
        int tick;
        hold = 0;
        tick = 0;
        score_if.ready = 1'b0;
        forever
        begin
            span = $urandom_range(20, 200);
            mode = $urandom_range(0, 3);
            repeat (span)
            begin
                @(negedge clk);
                tick++;
                if (hold_off_req)
                begin
                    hold_off_req = 1'b0;
                    hold = LONG_HOLD;
                end
                if (hold > 0)
                begin
                    hold--;
                    score_if.ready <= 1'b0;
                end
                else
                begin
                    case (mode)
                        0: score_if.ready <= 1'b1;
                        1: score_if.ready <= 1'($urandom_range(0, 1));
                        2: score_if.ready <= ($urandom_range(0, 3) == 0);
                        default: score_if.ready <= tick[2];
                    endcase
                end
            end
        end
    end

    always @(posedge clk)
    begin : score_check
        score_t want;
        if (rst_n && score_if.valid && score_if.ready)
        begin
            if (pending_means.size() == 0)
            begin
                $error("score transaction with none expected: mean_score %0d pixel_count %0d",
                       score_if.mean_score, score_if.pixel_count);
                fail_count++;
            end
            else
            begin
                want = pending_means.pop_front();
                if (score_if.mean_score !== want.mean)
                begin
                    $error("mean_score expected %0d actual %0d", want.mean, score_if.mean_score);
                    fail_count++;
                end
                if (score_if.pixel_count !== want.count)
                begin
                    $error("pixel_count expected %0d actual %0d", want.count, score_if.pixel_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((pix_if.valid && pix_if.ready) || (score_if.valid && score_if.ready)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
